FILE: rtl/core/assert_macros.svh
// assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLY(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/cawt_pkg.sv
package cawt_pkg;

    localparam int FRAME_WINDOW = 3;
    localparam int MAX_CHUNKS   = 128;
    localparam int WIN_W        = $clog2(FRAME_WINDOW + 1);
    localparam int CNT_W        = $clog2(MAX_CHUNKS + 1);

    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_CHUNKS0 = 2'd1;
    localparam logic [1:0] REG_CHUNKS1 = 2'd2;
    localparam logic [1:0] REG_IDLE = 2'd3;

    localparam logic [2:0] V_ACCEPT   = 3'd0;
    localparam logic [2:0] V_INVALID  = 3'd1;
    localparam logic [2:0] V_STALE    = 3'd2;
    localparam logic [2:0] V_OVERFLOW = 3'd3;
    localparam logic [2:0] V_IGNORED  = 3'd4;

    typedef struct packed {
        logic        header_ok;
        logic [31:0] session_id;
        logic [31:0] frame_id;
        logic        mode;
        logic [6:0]  chunk_index;
        logic [31:0] now_ms;
        logic        same_endpoint;
        logic        slot_free;
    } t_in;

    typedef struct packed {
        logic [2:0]  verdict;
        logic        new_session;
        logic        tail_feedback;
        logic [31:0] latest_rx_frame;
        logic [31:0] latest_complete_frame;
        logic [31:0] rx_count;
        logic [31:0] accepted_count;
        logic [31:0] overflow_count;
        logic [31:0] invalid_count;
        logic [31:0] stale_count;
    } t_out;

    // classified item handed from front to back
    typedef struct packed {
        t_in         item;
        logic        ignored;
        logic        bad;
        logic [7:0]  expected;
    } t_cls;

    function automatic logic is_newer(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic [7:0] clamp_chunks(input logic [7:0] c);
        if (c == 8'd0) return 8'd1;
        if (c > 8'(MAX_CHUNKS)) return 8'(MAX_CHUNKS);
        return c;
    endfunction

endpackage

FILE: rtl/core/chunk_admission_window_tracker.sv
// result path: input accept, then the queue stage, then the result register
// throughput: one item per cycle while the output is taken, set by the back-end window update
// the two-entry queue lets the front accept while a result waits
// reset: synchronous active low; clears session, window flags, counters, pointers
`include "assert_macros.svh"
module chunk_admission_window_tracker
    import cawt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic        r_enable;
    logic [7:0]  r_chunks0, r_chunks1;
    logic [15:0] r_idle;
    logic        q_valid, q_ready;
    t_cls        q_cls;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_chunks0 <= 8'd64;
            r_chunks1 <= 8'd128;
            r_idle <= 16'd250;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE:  r_enable <= i_cfg_data[0];
                REG_CHUNKS0: r_chunks0 <= i_cfg_data[7:0];
                REG_CHUNKS1: r_chunks1 <= i_cfg_data[7:0];
                REG_IDLE:    r_idle <= i_cfg_data[15:0];
                default:     r_idle <= r_idle;
            endcase
        end
    end

    cawt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready), .i_item(i_data),
        .i_enable(r_enable), .i_chunks0(r_chunks0), .i_chunks1(r_chunks1),
        .o_valid(q_valid), .i_ready(q_ready), .o_cls(q_cls)
    );

    cawt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_cls(q_cls),
        .i_idle_ms(r_idle),
        .o_valid(o_valid), .i_ready(i_ready), .o_item(o_data)
    );

    `ASSERT_IMPLY(a_tail_acc, i_clk, i_rst_n, o_valid && o_data.tail_feedback, o_data.verdict == V_ACCEPT)
    `ASSERT_IMPLY(a_ign_clean, i_clk, i_rst_n, o_valid && o_data.verdict == V_IGNORED, !o_data.new_session)
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)

endmodule

FILE: rtl/core/cawt_front.sv
module cawt_front
    import cawt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_item,
    input  logic        i_enable,
    input  logic [7:0]  i_chunks0,
    input  logic [7:0]  i_chunks1,
    output logic        o_valid,
    input  logic        i_ready,
    output t_cls        o_cls
);

    t_cls r_q [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    t_cls n_cls;
    logic push, pop;

    always_comb begin
        n_cls.item = i_item;
        n_cls.expected = clamp_chunks(i_item.mode ? i_chunks1 : i_chunks0);
        n_cls.ignored = !i_enable;
        n_cls.bad = !i_item.header_ok || ({1'b0, i_item.chunk_index} >= n_cls.expected);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push = i_valid && o_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign pop = o_valid && i_ready;
    assign o_cls = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) r_q[r_wp] <= n_cls;
    end

endmodule

FILE: rtl/core/cawt_back.sv
module cawt_back
    import cawt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_cls        i_cls,
    input  logic [15:0] i_idle_ms,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_item
);

    logic              r_sv;
    logic [31:0]       r_sess;
    logic              r_mode;
    logic [31:0]       r_last;
    logic              r_tv;
    logic [31:0]       r_newest;
    logic [FRAME_WINDOW-1:0] r_ev;
    logic [31:0]       r_ef [FRAME_WINDOW];
    logic [MAX_CHUNKS-1:0] r_em [FRAME_WINDOW];
    logic [7:0]        r_ec [FRAME_WINDOW];
    logic [CNT_W-1:0]  r_pc [FRAME_WINDOW];
    logic [31:0]       r_nrx, r_ncp;
    logic [31:0]       r_c [5];
    logic              r_ov;
    t_out              r_out;

    // combinational step
    logic              clr, acc, go;
    logic [2:0]        verd;
    logic              nsess, tail;
    logic [31:0]       frame;
    logic [6:0]        ck;
    logic [31:0]       nt;
    logic [FRAME_WINDOW-1:0] ev_b;
    logic              hit, found;
    logic [WIN_W-1:0]  hi, fi, oi, sel;
    logic              fv, ov;
    logic [31:0]       oage, age;
    logic              have, stale_w;
    logic [MAX_CHUNKS-1:0] m_new;
    logic [CNT_W-1:0]  p_new;
    logic [31:0]       nrx, ncp;
    logic [31:0]       c [5];
    logic              fresh, allowed;

    assign go = i_valid && o_ready;
    assign o_ready = !r_ov || i_ready;
    assign o_valid = r_ov;
    assign o_item = r_out;

    always_comb begin
        frame = i_cls.item.frame_id;
        ck = i_cls.item.chunk_index;
        verd = V_ACCEPT;
        nsess = 1'b0;
        tail = 1'b0;
        clr = 1'b0;
        acc = 1'b0;
        nt = r_newest;
        ev_b = r_ev;
        hit = 1'b0; hi = '0; fv = 1'b0; fi = '0; ov = 1'b0; oi = '0; oage = '0;
        age = '0; sel = '0; found = 1'b0; have = 1'b0; stale_w = 1'b0;
        m_new = '0; p_new = '0;
        nrx = r_nrx; ncp = r_ncp;
        for (int k = 0; k < 5; k++) c[k] = r_c[k];
        fresh = !r_sv || i_cls.item.session_id != r_sess;
        allowed = (ck == 7'd0) && (!r_sv || frame == 32'd0
                  || (i_cls.item.now_ms - r_last) >= {16'd0, i_idle_ms});
        if (i_cls.ignored) begin
            verd = V_IGNORED;
        end else if (i_cls.bad) begin
            c[3] = r_c[3] + 32'd1;
            verd = V_INVALID;
        end else begin
            if (fresh) begin
                if (!allowed) begin
                    c[4] = r_c[4] + 32'd1;
                    verd = V_STALE;
                end else begin
                    clr = 1'b1;
                    nsess = 1'b1;
                    for (int k = 0; k < 5; k++) c[k] = '0;
                    nrx = '1; ncp = '1;
                    ev_b = '0;
                    nt = frame;
                end
            end else if (!i_cls.item.same_endpoint || i_cls.item.mode != r_mode) begin
                c[4] = r_c[4] + 32'd1;
                verd = V_STALE;
            end
            if (verd == V_ACCEPT) begin
                c[0] = c[0] + 32'd1;
                if (!clr && r_tv && frame != r_newest) begin
                    if (is_newer(frame, r_newest)) nt = frame;
                    else if ((r_newest - frame) >= 32'(FRAME_WINDOW)) stale_w = 1'b1;
                end else if (!clr && !r_tv) begin
                    nt = frame;
                end
                if (!stale_w) begin
                    // entries scanned in order, aged ones dropped up to the match
                    for (int i = 0; i < FRAME_WINDOW; i++) begin
                        if (!hit) begin
                            age = nt - r_ef[i];
                            if (ev_b[i] && r_ef[i] == frame) begin
                                hit = 1'b1;
                                hi = WIN_W'(i);
                            end else if (!ev_b[i]) begin
                                fv = 1'b1; fi = WIN_W'(i);
                            end else if (age >= 32'(FRAME_WINDOW)) begin
                                ev_b[i] = 1'b0;
                                fv = 1'b1; fi = WIN_W'(i);
                            end else if (!ov || age > oage) begin
                                ov = 1'b1; oi = WIN_W'(i); oage = age;
                            end
                        end
                    end
                    found = hit || fv || ov;
                    sel = hit ? hi : (fv ? fi : oi);
                    if (found && !hit) ev_b[sel] = 1'b1;
                end
                if (!found) begin
                    c[4] = c[4] + 32'd1;
                    verd = V_STALE;
                end else begin
                    if (hit) begin
                        m_new = r_em[sel];
                        p_new = r_pc[sel];
                    end
                    have = m_new[ck];
                    if ((hit ? r_ec[sel] : i_cls.expected) != i_cls.expected || have) begin
                        c[4] = c[4] + 32'd1;
                        verd = V_STALE;
                    end else if (!i_cls.item.slot_free) begin
                        c[2] = c[2] + 32'd1;
                        verd = V_OVERFLOW;
                    end else begin
                        acc = 1'b1;
                        m_new[ck] = 1'b1;
                        p_new = p_new + CNT_W'(1);
                        if (nrx == '1 || frame == nrx || is_newer(frame, nrx)) nrx = frame;
                        if ({{(8-CNT_W+1){1'b0}}, p_new} == {1'b0, i_cls.expected}
                            && (ncp == '1 || is_newer(frame, ncp))) ncp = frame;
                        c[1] = c[1] + 32'd1;
                        tail = ({1'b0, ck} + 8'd1) == i_cls.expected;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv <= 1'b0; r_sess <= '0; r_mode <= 1'b0; r_last <= '0;
            r_tv <= 1'b0; r_newest <= '0; r_ev <= '0;
            r_nrx <= '1; r_ncp <= '1; r_ov <= 1'b0;
            for (int k = 0; k < 5; k++) r_c[k] <= '0;
        end else begin
            r_ov <= go || (r_ov && !i_ready);
            if (go) begin
                if (nsess) begin
                    r_sv <= 1'b1;
                    r_sess <= i_cls.item.session_id;
                    r_mode <= i_cls.item.mode;
                end
                if (!i_cls.ignored && !i_cls.bad && (nsess || !fresh)
                    && (nsess || (i_cls.item.same_endpoint && i_cls.item.mode == r_mode))) begin
                    r_tv <= 1'b1;
                    r_newest <= nt;
                    r_ev <= ev_b;
                end
                if (acc) r_last <= i_cls.item.now_ms;
                r_nrx <= nrx; r_ncp <= ncp;
                for (int k = 0; k < 5; k++) r_c[k] <= c[k];
            end
        end
        if (go && found) begin
            r_ef[sel] <= frame;
            r_ec[sel] <= hit ? r_ec[sel] : i_cls.expected;
            r_em[sel] <= acc ? m_new : (hit ? r_em[sel] : '0);
            r_pc[sel] <= acc ? p_new : (hit ? r_pc[sel] : '0);
        end
        if (go) begin
            r_out.verdict <= verd;
            r_out.new_session <= nsess;
            r_out.tail_feedback <= tail;
            r_out.latest_rx_frame <= nrx;
            r_out.latest_complete_frame <= ncp;
            r_out.rx_count <= c[0];
            r_out.accepted_count <= c[1];
            r_out.overflow_count <= c[2];
            r_out.invalid_count <= c[3];
            r_out.stale_count <= c[4];
        end
    end

endmodule
